[design/spa_pkg.sv]
package spa_pkg;

  // pool size and field widths
  localparam int SLOTS_DEFAULT = 32;
  localparam int SLOT_W        = 5;
  localparam int STATUS_W      = 2;
  localparam int CFG_W         = 6;
  localparam int MAX_POOL      = 32;

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 2'd2;

endpackage

[design/spa_chan_if.sv]
// request channel: allocate or release one slot
interface spa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [spa_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

// result channel: status and granted slot
interface spa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::STATUS_W-1:0] status;
  logic [spa_pkg::SLOT_W-1:0]   granted_slot;

  modport source (output valid, output status, output granted_slot, input ready);
  modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

[design/spa_link_mem.sv]
// next-link store: one write port, one read port, registered read data
module spa_link_mem #(
  parameter int DEPTH = spa_pkg::MAX_POOL,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/slot_pool_allocator.sv]
// Slot pool allocator.
// A request word on req carries kind (allocate / release) and, for a release,
// the slot number. Each request yields exactly one result word on rsp with a
// status and, for a successful allocate, the granted slot (zero otherwise).
// Requests are handled one at a time; req.ready is high only while the block
// is idle. The link store is a one-read one-write memory with registered
// read data.
// States a request passes through, from its acceptance to its result word:
// allocate goes through S_ALLOC, then S_DONE (straight to S_DONE if exhausted);
// release goes through S_WALK, one active-list entry per step, then S_TAIL and
// S_DONE; a refused release goes to S_DONE from S_IDLE or from S_WALK.
// Reset and every write to cfg_data rebuild the pool: the link store is
// swept one entry per cycle for the configured slot count while no request
// is taken. The result register decouples rsp: a new request is accepted
// while a result still waits, and a finished item holds until the result
// register frees up when the receiver stalls.
module slot_pool_allocator #(
  parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [spa_pkg::CFG_W-1:0] cfg_data,
  spa_req_if.sink                   req,
  spa_rsp_if.source                 rsp
);

  localparam int DEPTH = (SLOTS < spa_pkg::MAX_POOL) ? SLOTS : spa_pkg::MAX_POOL;
  localparam int LW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SLOTS + 1);
  localparam logic [LW-1:0]             LAST_IDX  = LW'(DEPTH - 1);
  localparam logic [spa_pkg::CFG_W-1:0] DEPTH_CFG = spa_pkg::CFG_W'(DEPTH);
  localparam logic [SW-1:0]             STEP_LAST = SW'(SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  logic [LW-1:0] n_last;
  logic [LW-1:0] init_idx;
  logic [LW-1:0] free_first;
  logic [LW-1:0] free_last;
  logic [LW-1:0] active_first;
  logic          active_nonempty;
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic          has_prev;
  logic [SW-1:0] steps;
  logic [LW-1:0] target;
  logic [spa_pkg::STATUS_W-1:0] res_status;
  logic [spa_pkg::SLOT_W-1:0]   res_slot;

  logic          mem_we;
  logic [LW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [LW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  logic [spa_pkg::CFG_W-1:0] cfg_clamped;
  logic [LW-1:0]             cfg_last;
  logic                      slot_in_pool;
  logic                      found;
  logic                      at_end;
  logic                      rsp_load;

  // clamp the configured count into [2, DEPTH]
  always_comb begin
    if (cfg_data < spa_pkg::CFG_W'(2)) begin
      cfg_clamped = spa_pkg::CFG_W'(2);
    end else if (cfg_data > DEPTH_CFG) begin
      cfg_clamped = DEPTH_CFG;
    end else begin
      cfg_clamped = cfg_data;
    end
  end
  assign cfg_last = LW'(cfg_clamped - spa_pkg::CFG_W'(1));

  assign slot_in_pool = {1'b0, req.slot} < DEPTH_CFG;
  assign found        = (cur == target);
  assign at_end       = (mem_rdata == cur);

  assign req.ready = (state == S_IDLE);

  // finished item moves into the result register once it is free
  assign rsp_load = !cfg_we && (state == S_DONE) && (!rsp.valid || rsp.ready);

  // link store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_idx;
        mem_wdata = (init_idx == n_last) ? init_idx : init_idx + LW'(1);
      end
      S_IDLE: begin
        mem_raddr = (req.kind == spa_pkg::KIND_RELEASE) ? active_first : free_first;
      end
      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = free_first;
        mem_wdata = active_nonempty ? active_first : free_first;
      end
      S_WALK: begin
        // follow the link read this cycle; unlink from predecessor when found
        mem_raddr = mem_rdata;
        mem_we    = found && has_prev;
        mem_waddr = prev;
        mem_wdata = at_end ? prev : mem_rdata;
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = free_last;
        mem_wdata = target;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  spa_link_mem #(
    .DEPTH (DEPTH),
    .AW    (LW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid        <= 1'b1;
      rsp.status       <= res_status;
      rsp.granted_slot <= res_slot;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // sequencer and list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      n_last          <= LAST_IDX;
      init_idx        <= '0;
      free_first      <= '0;
      free_last       <= LAST_IDX;
      active_first    <= '0;
      active_nonempty <= 1'b0;
      cur             <= '0;
      prev            <= '0;
      has_prev        <= 1'b0;
      steps           <= '0;
    end else begin
      if (cfg_we) begin
        // rebuild the pool
        state           <= S_INIT;
        n_last          <= cfg_last;
        init_idx        <= '0;
        free_first      <= '0;
        free_last       <= cfg_last;
        active_first    <= '0;
        active_nonempty <= 1'b0;
      end else begin
        case (state)
          S_INIT: begin
            init_idx <= init_idx + LW'(1);
            if (init_idx == n_last) begin
              state <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (req.valid) begin
              res_slot <= '0;
              if (req.kind == spa_pkg::KIND_ALLOC) begin
                if (free_first == free_last) begin
                  res_status <= spa_pkg::STATUS_EXHAUSTED;
                  state      <= S_DONE;
                end else begin
                  res_status <= spa_pkg::STATUS_DONE;
                  state      <= S_ALLOC;
                end
              end else if (active_nonempty && slot_in_pool) begin
                res_status <= spa_pkg::STATUS_DONE;
                cur        <= active_first;
                has_prev   <= 1'b0;
                steps      <= '0;
                target     <= LW'(req.slot);
                state      <= S_WALK;
              end else begin
                res_status <= spa_pkg::STATUS_NOT_ACTIVE;
                state      <= S_DONE;
              end
            end
          end

          S_ALLOC: begin
            // pop free head, push onto active list
            free_first      <= mem_rdata;
            active_first    <= free_first;
            active_nonempty <= 1'b1;
            res_slot        <= spa_pkg::SLOT_W'(free_first);
            state           <= S_DONE;
          end

          S_WALK: begin
            if (found) begin
              if (!has_prev) begin
                if (at_end) begin
                  active_nonempty <= 1'b0;
                end else begin
                  active_first <= mem_rdata;
                end
              end
              state <= S_TAIL;
            end else if (at_end || steps == STEP_LAST) begin
              res_status <= spa_pkg::STATUS_NOT_ACTIVE;
              state      <= S_DONE;
            end else begin
              prev     <= cur;
              has_prev <= 1'b1;
              cur      <= mem_rdata;
              steps    <= steps + SW'(1);
            end
          end

          S_TAIL: begin
            // released slot becomes the free tail
            free_last <= target;
            state     <= S_DONE;
          end

          S_DONE: begin
            if (rsp_load) begin
              state <= S_IDLE;
            end
          end

          default: begin
            state <= S_INIT;
          end
        endcase
      end
    end
  end

endmodule

[sim/slot_pool_allocator_test.sv]
`timescale 1ns / 100ps

module slot_pool_allocator_test;

  localparam int RUN_LIMIT   = 400000;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [spa_pkg::STATUS_W-1:0] status;
    logic [spa_pkg::SLOT_W-1:0]   granted;
  } pool_result_t;

  // Mirror of the pool: free list and active list over one link store.
  // Every accepted request word queues the result word it must produce.
  class slot_pool_scoreboard;
    logic [spa_pkg::SLOT_W-1:0] link [spa_pkg::MAX_POOL];
    logic [spa_pkg::SLOT_W-1:0] spare_head;
    logic [spa_pkg::SLOT_W-1:0] spare_tail;
    logic [spa_pkg::SLOT_W-1:0] active_head;
    bit                         active_any;
    pool_result_t               pending_results [$];
    int                         errors;

    // chain the first n slots into the free list, n saturated to [2, 32]
    function void rebuild(input logic [spa_pkg::CFG_W-1:0] value);
      int n;
      n = int'(value);
      if (n < 2) n = 2;
      if (n > spa_pkg::MAX_POOL) n = spa_pkg::MAX_POOL;
      for (int i = 0; i < spa_pkg::MAX_POOL; i++) begin
        link[i] = spa_pkg::SLOT_W'((i + 1 < spa_pkg::MAX_POOL) ? i + 1 : i);
      end
      link[n-1]   = spa_pkg::SLOT_W'(n - 1);
      spare_head  = '0;
      spare_tail  = spa_pkg::SLOT_W'(n - 1);
      active_head = '0;
      active_any  = 1'b0;
    endfunction

    // apply one request word, queue its result
    function void note_request(input logic kind, input logic [spa_pkg::SLOT_W-1:0] slot);
      pool_result_t               res;
      logic [spa_pkg::SLOT_W-1:0] cur;
      logic [spa_pkg::SLOT_W-1:0] prev;
      logic [spa_pkg::SLOT_W-1:0] nxt;
      logic [spa_pkg::SLOT_W-1:0] taken;
      bit                         has_prev;
      bit                         found;
      res.status  = spa_pkg::STATUS_DONE;
      res.granted = '0;
      if (kind == spa_pkg::KIND_ALLOC) begin
        // one slot always stays behind as the free sentinel
        if (spare_head == spare_tail) begin
          res.status = spa_pkg::STATUS_EXHAUSTED;
        end else begin
          taken       = spare_head;
          spare_head  = link[taken];
          link[taken] = active_any ? active_head : taken;
          active_head = taken;
          active_any  = 1'b1;
          res.granted = taken;
        end
      end else begin
        // search the active list for the slot and its predecessor
        cur      = active_head;
        prev     = '0;
        has_prev = 1'b0;
        found    = 1'b0;
        if (active_any) begin
          for (int steps = 0; steps < spa_pkg::MAX_POOL; steps++) begin
            if (cur == slot) begin
              found = 1'b1;
              break;
            end
            if (link[cur] == cur) break;
            prev     = cur;
            has_prev = 1'b1;
            cur      = link[cur];
          end
        end
        if (!found) begin
          res.status = spa_pkg::STATUS_NOT_ACTIVE;
        end else begin
          nxt              = link[slot];
          link[spare_tail] = slot;
          spare_tail       = slot;
          if (!has_prev) begin
            if (nxt == slot) active_any = 1'b0;
            else active_head = nxt;
          end else begin
            link[prev] = (nxt == slot) ? prev : nxt;
          end
        end
      end
      pending_results.push_back(res);
    endfunction

    // choose a random slot currently on the active list
    function bit pick_active(output logic [spa_pkg::SLOT_W-1:0] slot);
      logic [spa_pkg::SLOT_W-1:0] cur;
      int                         len;
      int                         target;
      slot = '0;
      if (!active_any) return 1'b0;
      cur = active_head;
      len = 1;
      while (link[cur] != cur && len < spa_pkg::MAX_POOL) begin
        cur = link[cur];
        len++;
      end
      target = int'($urandom_range(len - 1));
      cur    = active_head;
      repeat (target) cur = link[cur];
      slot = cur;
      return 1'b1;
    endfunction

    // compare one result word with the oldest queued one
    function void check_result(input logic [spa_pkg::STATUS_W-1:0] status,
                               input logic [spa_pkg::SLOT_W-1:0] granted);
      pool_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none queued, status %0d slot %0d",
                 $time, status, granted);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, status);
        errors++;
      end
      if (granted !== want.granted) begin
        $display("%0t: granted_slot mismatch, expected %0d, actual %0d",
                 $time, want.granted, granted);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [spa_pkg::CFG_W-1:0] cfg_data;
  int                        cycles;
  int                        hold_left;
  bit                        hold_req;
  bit                        calm;
  slot_pool_scoreboard       sb;

  spa_req_if req_ch ();
  spa_rsp_if rsp_ch ();

  slot_pool_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.status, rsp_ch.granted_slot);
    end
  end

  // offer one request word, with random idle cycles ahead of it
  task automatic send_request(input logic kind, input logic [spa_pkg::SLOT_W-1:0] slot);
    while (!calm && $urandom_range(99) < 16) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.slot  <= slot;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, slot);
    @(negedge clk);
  endtask

  // rewrite the pool size once all results are in and the block is idle
  task automatic set_pool_size(input logic [spa_pkg::CFG_W-1:0] value);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.rebuild(value);
  endtask

  // random traffic: mostly allocates and releases of live slots
  task automatic run_traffic(input int count, input int alloc_pct);
    logic                       kind;
    logic [spa_pkg::SLOT_W-1:0] slot;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < alloc_pct) begin
        kind = spa_pkg::KIND_ALLOC;
        slot = spa_pkg::SLOT_W'($urandom_range(31));
      end else begin
        kind = spa_pkg::KIND_RELEASE;
        if ($urandom_range(99) >= 85 || !sb.pick_active(slot)) begin
          slot = spa_pkg::SLOT_W'($urandom_range(31));
        end
      end
      send_request(kind, slot);
    end
  endtask

  logic [spa_pkg::CFG_W-1:0] pool_plan [10];

  initial begin
    sb           = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.kind  = spa_pkg::KIND_ALLOC;
    req_ch.slot  = '0;
    hold_req     = 1'b0;
    calm         = 1'b0;
    sb.rebuild(6'd32);
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full pool after reset
    send_request(spa_pkg::KIND_RELEASE, 5'd0);   // empty active list
    send_request(spa_pkg::KIND_ALLOC, 5'd31);    // slot field ignored
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_RELEASE, 5'd1);   // middle of active list
    send_request(spa_pkg::KIND_RELEASE, 5'd31);  // slot still on free list
    send_request(spa_pkg::KIND_RELEASE, 5'd2);   // active head
    send_request(spa_pkg::KIND_RELEASE, 5'd0);   // last active slot
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_RELEASE, 5'd3);

    // directed: smallest pool, exhaustion and slots outside the pool
    set_pool_size(6'd2);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);     // exhausted
    send_request(spa_pkg::KIND_RELEASE, 5'd31);  // outside the pool
    send_request(spa_pkg::KIND_RELEASE, 5'd0);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);     // comes from the old tail
    send_request(spa_pkg::KIND_ALLOC, 5'd0);     // exhausted again

    // directed: saturated counts
    set_pool_size(6'd0);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    set_pool_size(6'd1);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_RELEASE, 5'd0);
    set_pool_size(6'd63);
    send_request(spa_pkg::KIND_ALLOC, 5'd0);
    send_request(spa_pkg::KIND_RELEASE, 5'd30);

    // random phases over a spread of pool sizes
    pool_plan = '{6'd32, 6'd2, 6'd63, 6'd5, 6'd0, 6'd33, 6'd17, 6'd1, 6'd32, 6'd32};
    pool_plan[8] = spa_pkg::CFG_W'($urandom_range(63));
    for (int p = 0; p < 10; p++) begin
      set_pool_size(pool_plan[p]);
      calm = (p == 3);
      if (p == 6) hold_req = 1'b1;
      run_traffic(PHASE_ITEMS, (p % 2 == 0) ? 65 : 40);
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
design/spa_pkg.sv
design/spa_chan_if.sv
design/spa_link_mem.sv
design/slot_pool_allocator.sv
sim/slot_pool_allocator_test.sv
